/* sv/assert_macros.svh */
// Assertion macros for the block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("fail");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("fail");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

/* sv/irti_pkg.sv */
package irti_pkg;
   localparam logic [63:0] SIGN_BIT  = 64'h8000000000000000;
   localparam logic [63:0] EXP_MASK  = 64'h7ff0000000000000;
   localparam logic [63:0] FRAC_MASK = 64'h000fffffffffffff;
   localparam logic [63:0] HALF_BITS = 64'h3fe0000000000000;
   localparam logic [63:0] ONE_BITS  = 64'h3ff0000000000000;
   localparam logic [63:0] POS_INF   = 64'h7ff0000000000000;
   localparam logic [63:0] EMPTY_MARK = 64'hffffffffffffffff;
   localparam logic [63:0] QNAN_BITS = 64'h7ff8000000000000;
   localparam logic [10:0] EXP_BIAS  = 11'd1023;
   localparam logic [10:0] EXP_BIG   = 11'd1075;  // bias + 52

   typedef enum logic [2:0] {
      DEC_ILL = 3'd0, DEC_TRV = 3'd1, DEC_DEF = 3'd2, DEC_DAC = 3'd3, DEC_COM = 3'd4
   } dec_type;

   // per-endpoint work after the add stage
   typedef struct packed {
      logic [63:0] val;      // sum, or final value when done
      logic [63:0] mask;     // fraction mask, ones below the unit bit
      logic        done;     // val already final
      logic        tie;
   } end_type;
endpackage

/* sv/irti_round_add.sv */
module irti_round_add import irti_pkg::*; (
   input  logic [63:0] v,
   input  logic        upper,
   input  logic        away,
   output end_type     res
);
   logic [10:0] ex;
   logic [63:0] mag;
   logic [63:0] zero;
   logic [5:0]  sh;
   logic [63:0] half;

   always_comb begin
      ex   = v[62:52];
      mag  = v & ~SIGN_BIT;
      zero = upper ? 64'd0 : SIGN_BIT;
      sh   = 6'(EXP_BIG - ex);
      half = 64'd1 << (sh - 6'd1);
      res  = '0;
      // small magnitudes to zero or one
      if (ex < EXP_BIAS) begin
         res.done = 1'b1;
         if (mag == HALF_BITS) begin
            res.tie = 1'b1;
            res.val = away ? ((v & SIGN_BIT) | ONE_BITS) : zero;
         end else if (mag < HALF_BITS) begin
            res.val = zero;
         end else begin
            res.val = (v & SIGN_BIT) | ONE_BITS;
         end
      end else if (ex < EXP_BIG) begin
         res.val  = v + half;
         res.mask = (64'd1 << sh) - 64'd1;
      end else begin
         res.done = 1'b1;
         res.val  = v;
      end
   end
endmodule

/* sv/irti_round_clear.sv */
module irti_round_clear import irti_pkg::*; (
   input  end_type     e,
   input  logic        away,
   output logic [63:0] val,
   output logic        tie
);
   always_comb begin
      val = e.val;
      tie = e.tie;
      if (!e.done) begin
         tie = (e.val & e.mask) == 64'd0;
         // ties to even also clear the unit bit
         if (tie && !away) val = e.val & ~{e.mask[62:0], 1'b1};
         else              val = e.val & ~e.mask;
      end
   end
endmodule

/* sv/interval_round_to_integer_top.sv */
// Rounds a decorated binary64 interval to integers, one transaction per clock
// while the output register is not held. Stages: decode of NaN/empty, half-ulp
// add, tie detect and fraction clear, decoration merge. req_ready falls only
// while the output register is held.
module interval_round_to_integer_top import irti_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_lower_bits,
   input  logic [63:0] req_upper_bits,
   input  logic [2:0]  req_in_decoration,
   input  logic        req_tie_away,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_lower_bits,
   output logic [63:0] rsp_out_upper_bits,
   output logic [2:0]  rsp_out_decoration
);
`include "assert_macros.svh"
   logic        adv;
   logic [3:0]  v_ff;
   // stage 1
   logic [63:0] lo1_ff, hi1_ff;
   logic [2:0]  d1_ff;
   logic        a1_ff;
   // stage 2
   end_type     e_lo_in, e_hi_in, e_lo_ff, e_hi_ff;
   logic [2:0]  d2_ff;
   logic        a2_ff;
   // stage 3
   logic [63:0] r_lo_in, r_hi_in, r_lo_ff, r_hi_ff;
   logic        t_lo, t_hi, t3_ff;
   logic [2:0]  d3_ff;
   // stage 4
   logic [63:0] o_lo_in, o_hi_in, o_lo_ff, o_hi_ff;
   logic [2:0]  o_d_in, o_d_ff, dc;

   assign adv       = !v_ff[3] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = v_ff[3];
   assign rsp_out_lower_bits = o_lo_ff;
   assign rsp_out_upper_bits = o_hi_ff;
   assign rsp_out_decoration = o_d_ff;

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[2:0], req_valid};
   end

   irti_round_add u_add_lo (.v(lo1_ff), .upper(1'b0), .away(a1_ff), .res(e_lo_in));
   irti_round_add u_add_hi (.v(hi1_ff), .upper(1'b1), .away(a1_ff), .res(e_hi_in));
   irti_round_clear u_clr_lo (.e(e_lo_ff), .away(a2_ff), .val(r_lo_in), .tie(t_lo));
   irti_round_clear u_clr_hi (.e(e_hi_ff), .away(a2_ff), .val(r_hi_in), .tie(t_hi));

   // merge decoration
   always_comb begin
      dc = t3_ff ? DEC_DAC : DEC_COM;
      o_lo_in = r_lo_ff;
      o_hi_in = r_hi_ff;
      if (r_lo_ff != r_hi_ff && !(r_lo_ff == SIGN_BIT && r_hi_ff == 64'd0)) begin
         if (r_hi_ff == EMPTY_MARK) begin
            o_lo_in = QNAN_BITS;
            o_hi_in = QNAN_BITS;
            dc = DEC_TRV;
         end else begin
            dc = DEC_DEF;
         end
      end
      o_d_in = (dc < d3_ff) ? dc : d3_ff;
      if (d3_ff == DEC_ILL) begin
         o_lo_in = QNAN_BITS;
         o_hi_in = QNAN_BITS;
         o_d_in  = DEC_ILL;
      end
   end

   // hold all stages on stall
   always_ff @(posedge clock) begin
      if (adv) begin
         lo1_ff  <= ((req_lower_bits & EXP_MASK) == EXP_MASK && (req_lower_bits & FRAC_MASK) != 0)
                    ? POS_INF : req_lower_bits;
         hi1_ff  <= ((req_upper_bits & EXP_MASK) == EXP_MASK && (req_upper_bits & FRAC_MASK) != 0)
                    ? EMPTY_MARK : req_upper_bits;
         d1_ff   <= req_in_decoration;
         a1_ff   <= req_tie_away;
         e_lo_ff <= e_lo_in;
         e_hi_ff <= e_hi_in;
         d2_ff   <= d1_ff;
         a2_ff   <= a1_ff;
         r_lo_ff <= r_lo_in;
         r_hi_ff <= r_hi_in;
         t3_ff   <= t_lo | t_hi;
         d3_ff   <= d2_ff;
         o_lo_ff <= o_lo_in;
         o_hi_ff <= o_hi_in;
         o_d_ff  <= o_d_in;
      end
   end

   `ASSERT_IMPLIES(a_ill, clock, reset, rsp_valid && rsp_out_decoration == DEC_ILL,
      rsp_out_lower_bits == QNAN_BITS)
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(o_d_ff))
   `ASSERT_IMPLIES(a_rdy, clock, reset, !rsp_valid, req_ready)
endmodule
